// ===== rtl/kecq_pkg.sv =====
`default_nettype none

package kecq_pkg;

    localparam int QUEUE_DEPTH    = 32;
    localparam int KEY_TABLE_SIZE = 256;

    localparam int CODE_W  = 10;
    localparam int KIND_W  = 2;
    localparam int FLAGS_W = 8;
    localparam int REQ_W   = 2;

    // queue occupancy counts 0..QUEUE_DEPTH
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int MAP_W = (KEY_TABLE_SIZE > 1) ? $clog2(KEY_TABLE_SIZE) : 1;

    localparam int INJECTED_BIT = 4;

    localparam logic [REQ_W-1:0] REQ_KEY   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DRAIN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    localparam logic [KIND_W-1:0] KIND_DOWN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UP     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 2'd2;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [KIND_W-1:0]  kind;
        logic [FLAGS_W-1:0] flags;
    } kecq_entry_t;

    typedef struct packed {
        logic shift;      // take neighbor's entry
        logic load;       // take the new entry
        logic upd_flags;  // overwrite flags only (collapsed repeat)
    } kecq_cell_ctrl_t;

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_CLASSIFY = 4'b0010,
        ST_DRAIN    = 4'b0100,
        ST_CLEAR    = 4'b1000
    } kecq_state_t;

endpackage

`default_nettype wire

// ===== rtl/key_event_classifier_queue_unit.sv =====
// Key event classifier with an event queue.
// Input channel (s_valid/s_ready): one request per transaction. A key event is
// classified against the pressed-key bitmap and queued; a clear empties the queue
// and bitmap; a drain emits the queue on the result channel, a disabled drain discards it.
// Result channel (m_valid/m_ready): one queued event per transaction, oldest
// first, is_last on the final one; a drain of an empty queue gives a single
// transaction with queue_empty and is_last set.
// For a key event, the bitmap is read at acceptance, then the bitmap and the
// queue tail are written in the next cycle. Ignored events, unused requests
// and disabled drains leave the input ready, so they can follow back to back.
// A clear holds off the input while the bitmap memory (KEY_TABLE_SIZE, 256
// entries) is zeroed one entry per cycle; the same pass runs after reset.
// A drain holds off the input until its last result (for an empty queue, the
// empty marker) is loaded into the output register; the drain state moves
// the head of the chain there, one entry per cycle while the register is free.
// When the receiver stalls, the output register holds and the chain waits.
// cfg_wr_en/cfg_wr_data write listen_enable.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result, clears listen_enable and starts the bitmap clearing pass.
`default_nettype none

module key_event_classifier_queue_unit
    import kecq_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic               cfg_wr_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [REQ_W-1:0]   s_req_type,
    input  wire logic [CODE_W-1:0]  s_key_code,
    input  wire logic               s_key_up,
    input  wire logic [FLAGS_W-1:0] s_event_flags,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [CODE_W-1:0]       m_out_key_code,
    output logic [KIND_W-1:0]       m_event_kind,
    output logic [FLAGS_W-1:0]      m_out_flags,
    output logic                    m_is_last,
    output logic                    m_queue_empty
);

    logic                      listen_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CODE_W-1:0]         last_code_reg, last_code_next;
    logic [KIND_W-1:0]         last_kind_reg, last_kind_next;
    logic [CODE_W-1:0]         ev_code_reg, ev_code_next;
    logic                      ev_up_reg, ev_up_next;
    logic [FLAGS_W-1:0]        ev_flags_reg, ev_flags_next;
    logic [MAP_W-1:0]          clr_idx_reg, clr_idx_next;
    logic                      map_rd_reg;
    kecq_state_t               state_reg, state_next;
    logic                      m_valid_reg, m_valid_next;
    kecq_entry_t               out_entry_reg, out_entry_next;
    logic                      out_last_reg, out_last_next;
    logic                      out_empty_reg, out_empty_next;

    // pressed-key bitmap
    logic             map_mem [KEY_TABLE_SIZE];
    logic             map_we, map_wdata;
    logic [MAP_W-1:0] map_waddr;

    kecq_entry_t     cell_q [QUEUE_DEPTH];
    kecq_cell_ctrl_t cell_ctrl [QUEUE_DEPTH];
    kecq_entry_t     new_entry;

    logic             accept, is_key, is_drain, is_clear, ev_ok, classify;
    logic             tracked, repl, full, ofree;
    logic             push_new, push_repl, drain_pop, shift_all;
    logic [KIND_W-1:0] kind;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign is_key   = (s_req_type == REQ_KEY);
    assign is_drain = (s_req_type == REQ_DRAIN);
    assign is_clear = (s_req_type == REQ_CLEAR);
    assign ev_ok    = listen_reg && !s_event_flags[INJECTED_BIT];
    assign classify = (state_reg == ST_CLASSIFY);

    assign tracked = ({1'b0, ev_code_reg} < (CODE_W + 1)'(KEY_TABLE_SIZE));

    always_comb begin
        if (ev_up_reg) begin
            kind = KIND_UP;
        end else if (tracked && map_rd_reg) begin
            kind = KIND_REPEAT;
        end else begin
            kind = KIND_DOWN;
        end
    end

    assign new_entry = '{code: ev_code_reg, kind: kind, flags: ev_flags_reg};

    // a repeat right after a repeat of the same key only refreshes the flags
    assign repl = (count_reg != '0) && (kind == KIND_REPEAT)
               && (last_kind_reg == KIND_REPEAT) && (last_code_reg == ev_code_reg);
    assign full = (count_reg == CNT_W'(QUEUE_DEPTH));

    assign push_repl = classify && repl;
    assign push_new  = classify && !repl;

    assign ofree     = !m_valid_reg || m_ready;
    assign drain_pop = (state_reg == ST_DRAIN) && ofree && (count_reg != '0);
    // full queue drops the oldest: whole chain shifts while the tail loads
    assign shift_all = drain_pop || (push_new && full);

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            kecq_entry_t nbr;
            if (gi == QUEUE_DEPTH - 1) begin : g_tail
                assign nbr = '0;
            end else begin : g_mid
                assign nbr = cell_q[gi+1];
            end

            always_comb begin
                cell_ctrl[gi].shift     = shift_all;
                cell_ctrl[gi].load      = push_new &&
                    (full ? (gi == QUEUE_DEPTH - 1) : (count_reg == CNT_W'(gi)));
                cell_ctrl[gi].upd_flags = push_repl &&
                    (count_reg == CNT_W'(gi + 1));
            end

            kecq_cell u_cell (
                .aclk      (aclk),
                .ctrl      (cell_ctrl[gi]),
                .new_entry (new_entry),
                .nbr_entry (nbr),
                .entry     (cell_q[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        if (accept) begin
            map_rd_reg <= map_mem[s_key_code[MAP_W-1:0]];
        end
    end

    always_comb begin
        count_next     = count_reg;
        last_code_next = last_code_reg;
        last_kind_next = last_kind_reg;
        ev_code_next   = ev_code_reg;
        ev_up_next     = ev_up_reg;
        ev_flags_next  = ev_flags_reg;
        clr_idx_next   = clr_idx_reg;
        state_next     = state_reg;
        m_valid_next   = m_valid_reg;
        out_entry_next = out_entry_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        map_we         = 1'b0;
        map_waddr      = clr_idx_reg;
        map_wdata      = 1'b0;

        if (accept && is_key) begin
            ev_code_next  = s_key_code;
            ev_up_next    = s_key_up;
            ev_flags_next = s_event_flags;
            if (ev_ok) begin
                state_next = ST_CLASSIFY;
            end
        end

        if (push_new) begin
            last_code_next = ev_code_reg;
            last_kind_next = kind;
            if (!full) begin
                count_next = count_reg + CNT_W'(1);
            end
        end

        if (accept && is_clear) begin
            count_next   = '0;
            clr_idx_next = '0;
            state_next   = ST_CLEAR;
        end

        if (accept && is_drain) begin
            if (listen_reg) begin
                state_next = ST_DRAIN;
            end else begin
                count_next = '0;
            end
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
            end
            ST_CLASSIFY: begin
                state_next = ST_IDLE;
                if (tracked && (kind != KIND_REPEAT)) begin
                    map_we    = 1'b1;
                    map_waddr = ev_code_reg[MAP_W-1:0];
                    map_wdata = (kind == KIND_DOWN);
                end
            end
            ST_DRAIN: begin
                if (ofree) begin
                    m_valid_next = 1'b1;
                    if (count_reg == '0) begin
                        out_entry_next = '0;
                        out_last_next  = 1'b1;
                        out_empty_next = 1'b1;
                        state_next     = ST_IDLE;
                    end else begin
                        out_entry_next = cell_q[0];
                        out_last_next  = (count_reg == CNT_W'(1));
                        out_empty_next = 1'b0;
                        count_next     = count_reg - CNT_W'(1);
                        if (count_reg == CNT_W'(1)) begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_CLEAR: begin
                map_we       = 1'b1;
                clr_idx_next = clr_idx_reg + MAP_W'(1);
                if (clr_idx_reg == MAP_W'(KEY_TABLE_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            listen_reg  <= 1'b0;
            count_reg   <= '0;
            clr_idx_reg <= '0;
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                listen_reg <= cfg_wr_data;
            end
            count_reg   <= count_next;
            clr_idx_reg <= clr_idx_next;
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        last_code_reg <= last_code_next;
        last_kind_reg <= last_kind_next;
        ev_code_reg   <= ev_code_next;
        ev_up_reg     <= ev_up_next;
        ev_flags_reg  <= ev_flags_next;
        out_entry_reg <= out_entry_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_key_code = out_entry_reg.code;
    assign m_event_kind   = out_entry_reg.kind;
    assign m_out_flags    = out_entry_reg.flags;
    assign m_is_last      = out_last_reg;
    assign m_queue_empty  = out_empty_reg;

endmodule

`default_nettype wire

// ===== rtl/kecq_cell.sv =====
`default_nettype none

module kecq_cell
    import kecq_pkg::*;
(
    input  wire logic            aclk,
    input  wire kecq_cell_ctrl_t ctrl,
    input  wire kecq_entry_t     new_entry,
    input  wire kecq_entry_t     nbr_entry,
    output kecq_entry_t          entry
);

    kecq_entry_t entry_reg;
    kecq_entry_t entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.load) begin
            entry_next = new_entry;
        end else if (ctrl.shift) begin
            entry_next = nbr_entry;
        end else if (ctrl.upd_flags) begin
            entry_next.flags = new_entry.flags;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire
